/* hw/rtl/fvm_pkg.sv */
// shared types and constants for the four-vector mass and pt bin block
`default_nettype none

package fvm_pkg;

	localparam int EDGE_BITS    = 24;
	localparam int EDGE_SQ_BITS = 2 * EDGE_BITS;
	localparam int CFG_IDX_BITS = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_PT_EDGE_LOW  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PT_EDGE_MID  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PT_EDGE_HIGH = 2'd2;

	localparam int EDGE_LOW_RESET  = 10000;
	localparam int EDGE_MID_RESET  = 20000;
	localparam int EDGE_HIGH_RESET = 30000;

	localparam logic [EDGE_SQ_BITS-1:0] EDGE_LOW_SQ_RESET  =
		EDGE_SQ_BITS'(EDGE_LOW_RESET * EDGE_LOW_RESET);
	localparam logic [EDGE_SQ_BITS-1:0] EDGE_MID_SQ_RESET  =
		EDGE_SQ_BITS'(EDGE_MID_RESET * EDGE_MID_RESET);
	localparam logic [EDGE_SQ_BITS-1:0] EDGE_HIGH_SQ_RESET =
		EDGE_SQ_BITS'(EDGE_HIGH_RESET * EDGE_HIGH_RESET);

	// pt bin codes
	localparam logic [1:0] PT_BIN_BELOW_LOW  = 2'd0;
	localparam logic [1:0] PT_BIN_BELOW_MID  = 2'd1;
	localparam logic [1:0] PT_BIN_BELOW_HIGH = 2'd2;
	localparam logic [1:0] PT_BIN_ABOVE_HIGH = 2'd3;

	// per-transaction side data that travels alongside the square root
	typedef struct packed {
		logic       mass_valid;
		logic [1:0] pt_bin;
	} side_t;

endpackage

`default_nettype wire

/* hw/rtl/four_vector_mass_and_pt_bin.sv */
// top level: invariant mass and transverse momentum bin of a four-vector
//
// input channel: in_valid / in_stall with mom_x, mom_y, mom_z (signed) and
// energy (unsigned); one transaction is one particle four-vector
// output channel: out_valid / out_stall with mass, mass_valid and pt_bin
// configuration: cfg_wr_en, cfg_index, cfg_wdata write the three pt edges
// (index 0 low, 1 mid, 2 high); other indexes are ignored; write only idle
// pipeline: magnitude, squares, sums, radicand and bin compare, then one
// square root bit per stage
// throughput: one transaction per cycle while out_stall is low, set by the fully pipelined root
// a negative radicand gives mass 0 with mass_valid low; pt_bin still valid
// reset: all stages empty, edges back to 10000, 20000 and 30000 MeV
// when out_stall is high, the pipeline keeps accepting until its empty
// stages fill up, then in_stall rises; nothing is lost or repeated
`default_nettype none

module four_vector_mass_and_pt_bin import fvm_pkg::*; #(
	parameter int MOMENTUM_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [MOMENTUM_BITS-1:0] mom_x,
	input  wire logic signed [MOMENTUM_BITS-1:0] mom_y,
	input  wire logic signed [MOMENTUM_BITS-1:0] mom_z,
	input  wire logic        [MOMENTUM_BITS-1:0] energy,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic             [MOMENTUM_BITS-1:0] mass,
	output logic                                 mass_valid,
	output logic             [1:0]               pt_bin,
	input  wire logic                            cfg_wr_en,
	input  wire logic        [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic        [EDGE_BITS-1:0]     cfg_wdata
);

	localparam int W       = MOMENTUM_BITS;
	localparam int SqBits  = 2 * W;
	localparam int Pt2Bits = SqBits + 1;
	localparam int DifBits = SqBits + 2;
	localparam int CmpBits = (Pt2Bits > EDGE_SQ_BITS) ? Pt2Bits : EDGE_SQ_BITS;

	// squared edges
	logic [EDGE_SQ_BITS-1:0] edge_low_sq_q;
	logic [EDGE_SQ_BITS-1:0] edge_mid_sq_q;
	logic [EDGE_SQ_BITS-1:0] edge_high_sq_q;
	logic [EDGE_SQ_BITS-1:0] cfg_sq;

	assign cfg_sq = EDGE_SQ_BITS'(cfg_wdata) * EDGE_SQ_BITS'(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_low_sq_q  <= EDGE_LOW_SQ_RESET;
			edge_mid_sq_q  <= EDGE_MID_SQ_RESET;
			edge_high_sq_q <= EDGE_HIGH_SQ_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_PT_EDGE_LOW:  edge_low_sq_q  <= cfg_sq;
				REG_PT_EDGE_MID:  edge_mid_sq_q  <= cfg_sq;
				REG_PT_EDGE_HIGH: edge_high_sq_q <= cfg_sq;
				default: ;
			endcase
		end
	end

	// pipeline registers
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [W-1:0]       mag_x_s1, mag_y_s1, mag_z_s1, e_s1;
	logic [SqBits-1:0]  x2_s2, y2_s2, z2_s2, e2_s2;
	logic [Pt2Bits-1:0] pt2_s3;
	logic [DifBits-1:0] ez_s3;
	logic [SqBits-1:0]  radicand_s4;
	side_t              side_s4;

	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic sq_in_stall;

	assign rdy_s4   = !v_s4 || !sq_in_stall;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// stage 1: magnitudes
	logic [W-1:0] mag_x_nx, mag_y_nx, mag_z_nx;

	assign mag_x_nx = mom_x[W-1] ? (W'(~mom_x) + W'(1)) : W'(mom_x);
	assign mag_y_nx = mom_y[W-1] ? (W'(~mom_y) + W'(1)) : W'(mom_y);
	assign mag_z_nx = mom_z[W-1] ? (W'(~mom_z) + W'(1)) : W'(mom_z);

	// stage 3: pt squared and energy squared minus z squared
	logic [Pt2Bits-1:0] pt2_nx;
	logic [DifBits-1:0] ez_nx;

	assign pt2_nx = Pt2Bits'(x2_s2) + Pt2Bits'(y2_s2);
	assign ez_nx  = DifBits'(e2_s2) - DifBits'(z2_s2);

	// stage 4: radicand, sign and pt bin
	logic [DifBits-1:0] rad_nx;
	logic               rad_neg;
	logic [CmpBits-1:0] pt2_cmp;
	logic [1:0]         bin_nx;
	side_t              side_nx;

	assign rad_nx  = ez_s3 - DifBits'(pt2_s3);
	assign rad_neg = rad_nx[DifBits-1];
	assign pt2_cmp = CmpBits'(pt2_s3);

	always_comb begin
		priority if (pt2_cmp < CmpBits'(edge_low_sq_q)) begin
			bin_nx = PT_BIN_BELOW_LOW;
		end else if (pt2_cmp < CmpBits'(edge_mid_sq_q)) begin
			bin_nx = PT_BIN_BELOW_MID;
		end else if (pt2_cmp < CmpBits'(edge_high_sq_q)) begin
			bin_nx = PT_BIN_BELOW_HIGH;
		end else begin
			bin_nx = PT_BIN_ABOVE_HIGH;
		end
	end

	assign side_nx.mass_valid = !rad_neg;
	assign side_nx.pt_bin     = bin_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mag_x_s1 <= mag_x_nx;
			mag_y_s1 <= mag_y_nx;
			mag_z_s1 <= mag_z_nx;
			e_s1     <= energy;
		end
		if (rdy_s2 && v_s1) begin
			x2_s2 <= SqBits'(mag_x_s1) * SqBits'(mag_x_s1);
			y2_s2 <= SqBits'(mag_y_s1) * SqBits'(mag_y_s1);
			z2_s2 <= SqBits'(mag_z_s1) * SqBits'(mag_z_s1);
			e2_s2 <= SqBits'(e_s1) * SqBits'(e_s1);
		end
		if (rdy_s3 && v_s2) begin
			pt2_s3 <= pt2_nx;
			ez_s3  <= ez_nx;
		end
		if (rdy_s4 && v_s3) begin
			radicand_s4 <= rad_neg ? '0 : rad_nx[SqBits-1:0];
			side_s4     <= side_nx;
		end
	end

	side_t out_side;

	fvm_sqrt #(
		.RootBits (W)
	) u_sqrt (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s4),
		.in_stall    (sq_in_stall),
		.in_radicand (radicand_s4),
		.in_side     (side_s4),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_root    (mass),
		.out_side    (out_side)
	);

	assign mass_valid = out_side.mass_valid;
	assign pt_bin     = out_side.pt_bin;

`ifndef SYNTHESIS
	// a negative radicand must come out as a zero mass
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mass_valid |-> mass == '0)
		else $error("invalid mass is not zero");

	// an accepted transaction lands in the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted transaction lost at stage 1");

	// with the output draining, the input is never held off
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output drains");
`endif

endmodule

`default_nettype wire

/* hw/rtl/fvm_sqrt.sv */
// pipelined floor square root, one result bit per stage
`default_nettype none

module fvm_sqrt import fvm_pkg::*; #(
	parameter int RootBits = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [2*RootBits-1:0]   in_radicand,
	input  wire side_t                   in_side,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [RootBits-1:0]          out_root,
	output side_t                        out_side
);

	localparam int RemBits = RootBits + 2;
	localparam int RadBits = 2 * RootBits;

	logic [RootBits-1:0] v_s;
	logic [RadBits-1:0]  rad_s  [RootBits];
	logic [RemBits-1:0]  rem_s  [RootBits];
	logic [RootBits-1:0] root_s [RootBits];
	side_t               side_s [RootBits];

	logic [RootBits:0]   rdy;
	logic [RootBits-1:0] v_in;
	logic [RadBits-1:0]  rad_in   [RootBits];
	logic [RemBits-1:0]  rem_in   [RootBits];
	logic [RootBits-1:0] root_in  [RootBits];
	side_t               side_in  [RootBits];
	logic [RadBits-1:0]  rad_nx   [RootBits];
	logic [RemBits-1:0]  rem_nx   [RootBits];
	logic [RootBits-1:0] root_nx  [RootBits];

	// stage inputs
	always_comb begin
		v_in[0]    = in_valid;
		rad_in[0]  = in_radicand;
		rem_in[0]  = '0;
		root_in[0] = '0;
		side_in[0] = in_side;
		for (int k = 1; k < RootBits; k++) begin
			v_in[k]    = v_s[k-1];
			rad_in[k]  = rad_s[k-1];
			rem_in[k]  = rem_s[k-1];
			root_in[k] = root_s[k-1];
			side_in[k] = side_s[k-1];
		end
	end

	// one restoring digit step per stage
	always_comb begin
		logic [RemBits-1:0] cur;
		logic [RemBits-1:0] trial;
		logic               ge;
		cur   = '0;
		trial = '0;
		ge    = 1'b0;
		for (int k = 0; k < RootBits; k++) begin
			cur        = {rem_in[k][RootBits-1:0], rad_in[k][RadBits-1 -: 2]};
			trial      = {root_in[k], 2'b01};
			ge         = (cur >= trial);
			rem_nx[k]  = ge ? (cur - trial) : cur;
			root_nx[k] = {root_in[k][RootBits-2:0], ge};
			rad_nx[k]  = {rad_in[k][RadBits-3:0], 2'b00};
		end
	end

	// a stage can load when it is empty or its content moves on
	always_comb begin
		rdy[RootBits] = !out_stall;
		for (int k = RootBits - 1; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end

	assign in_stall = !rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			for (int k = 0; k < RootBits; k++) begin
				if (rdy[k]) begin
					v_s[k] <= v_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < RootBits; k++) begin
			if (rdy[k] && v_in[k]) begin
				rad_s[k]  <= rad_nx[k];
				rem_s[k]  <= rem_nx[k];
				root_s[k] <= root_nx[k];
				side_s[k] <= side_in[k];
			end
		end
	end

	assign out_valid = v_s[RootBits-1];
	assign out_root  = root_s[RootBits-1];
	assign out_side  = side_s[RootBits-1];

endmodule

`default_nettype wire

/* dv/mass_pt_checker.sv */
// checker for the four-vector mass and pt bin block: predicts and compares each result
`timescale 1ns / 100ps
`default_nettype none

module mass_pt_checker import fvm_pkg::*; #(
	parameter int MOMENTUM_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic signed [MOMENTUM_BITS-1:0] mom_x,
	input  wire logic signed [MOMENTUM_BITS-1:0] mom_y,
	input  wire logic signed [MOMENTUM_BITS-1:0] mom_z,
	input  wire logic        [MOMENTUM_BITS-1:0] energy,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic        [MOMENTUM_BITS-1:0] mass,
	input  wire logic                            mass_valid,
	input  wire logic        [1:0]               pt_bin,
	input  wire logic                            cfg_wr_en,
	input  wire logic        [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic        [EDGE_BITS-1:0]     cfg_wdata,
	output int                                   outstanding,
	output int                                   err_count
);

	typedef struct packed {
		logic [MOMENTUM_BITS-1:0] mass;
		logic                     mass_valid;
		logic [1:0]               pt_bin;
	} particle_result_t;

	particle_result_t expected_q[$];
	logic [EDGE_BITS-1:0] edge_low, edge_mid, edge_high;

	function automatic longint unsigned square_of_signed(logic signed [MOMENTUM_BITS-1:0] v);
		longint m;
		m = v;
		if (m < 0)
			m = -m;
		return longint'(m) * longint'(m);
	endfunction

	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned rem, root, b;
		rem = v;
		root = 0;
		b = 64'h1 << 62;
		while (b > rem)
			b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic particle_result_t predict_particle(
		logic signed [MOMENTUM_BITS-1:0] px, logic signed [MOMENTUM_BITS-1:0] py,
		logic signed [MOMENTUM_BITS-1:0] pz, logic [MOMENTUM_BITS-1:0] e);
		particle_result_t r;
		longint unsigned pt_sq, p_sq, e_sq, lo_sq, mid_sq, hi_sq, ev;
		pt_sq  = square_of_signed(px) + square_of_signed(py);
		p_sq   = pt_sq + square_of_signed(pz);
		ev     = e;
		e_sq   = ev * ev;
		lo_sq  = longint'(edge_low) * longint'(edge_low);
		mid_sq = longint'(edge_mid) * longint'(edge_mid);
		hi_sq  = longint'(edge_high) * longint'(edge_high);
		if (e_sq >= p_sq) begin
			r.mass_valid = 1'b1;
			r.mass = MOMENTUM_BITS'(floor_root(e_sq - p_sq));
		end else begin
			r.mass_valid = 1'b0;
			r.mass = '0;
		end
		if (pt_sq < lo_sq)
			r.pt_bin = PT_BIN_BELOW_LOW;
		else if (pt_sq < mid_sq)
			r.pt_bin = PT_BIN_BELOW_MID;
		else if (pt_sq < hi_sq)
			r.pt_bin = PT_BIN_BELOW_HIGH;
		else
			r.pt_bin = PT_BIN_ABOVE_HIGH;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	assign outstanding = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		particle_result_t want;
		if (!arst_n) begin
			expected_q.delete();
			err_count = 0;
			edge_low  <= EDGE_BITS'(EDGE_LOW_RESET);
			edge_mid  <= EDGE_BITS'(EDGE_MID_RESET);
			edge_high <= EDGE_BITS'(EDGE_HIGH_RESET);
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected transaction, mass", mass, 0);
				end else begin
					want = expected_q.pop_front();
					if (mass !== want.mass)
						report_mismatch("mass", mass, want.mass);
					if (mass_valid !== want.mass_valid)
						report_mismatch("mass_valid", mass_valid, want.mass_valid);
					if (pt_bin !== want.pt_bin)
						report_mismatch("pt_bin", pt_bin, want.pt_bin);
				end
			end
			if (in_valid && !in_stall)
				expected_q.insert(expected_q.size(),
					predict_particle(mom_x, mom_y, mom_z, energy));
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_PT_EDGE_LOW:  edge_low  <= cfg_wdata;
					REG_PT_EDGE_MID:  edge_mid  <= cfg_wdata;
					REG_PT_EDGE_HIGH: edge_high <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

/* dv/tb.sv */
// testbench top for the four-vector mass and pt bin block: stimulus, config and verdict
`timescale 1ns / 100ps
`default_nettype none

module tb import fvm_pkg::*;;

	localparam int MB = 24;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int NUM_PHASES = 6;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
	localparam longint EDGE_MAX = 16777215;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic signed [MB-1:0]   mom_x, mom_y, mom_z;
	logic        [MB-1:0]   energy;
	logic                   out_valid;
	logic                   out_stall;
	logic        [MB-1:0]   mass;
	logic                   mass_valid;
	logic        [1:0]      pt_bin;
	logic                   cfg_wr_en;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [EDGE_BITS-1:0]   cfg_wdata;
	int                     outstanding;
	int                     err_count;
	int                     send_gap_pct;
	int                     stall_pct;
	longint                 cur_edge [3];

	four_vector_mass_and_pt_bin #(.MOMENTUM_BITS(MB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z), .energy(energy),
		.out_valid(out_valid), .out_stall(out_stall),
		.mass(mass), .mass_valid(mass_valid), .pt_bin(pt_bin),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	mass_pt_checker #(.MOMENTUM_BITS(MB)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z), .energy(energy),
		.out_valid(out_valid), .out_stall(out_stall),
		.mass(mass), .mass_valid(mass_valid), .pt_bin(pt_bin),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.outstanding(outstanding), .err_count(err_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	// entered and left at a falling edge
	task automatic send_particle(longint x, longint y, longint z, longint e);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mom_x    <= x[MB-1:0];
		mom_y    <= y[MB-1:0];
		mom_z    <= z[MB-1:0];
		energy   <= e[MB-1:0];
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_edges(longint lo, longint mid, longint hi);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_PT_EDGE_LOW;
		cfg_wdata <= lo[EDGE_BITS-1:0];
		@(negedge clk);
		cfg_index <= REG_PT_EDGE_MID;
		cfg_wdata <= mid[EDGE_BITS-1:0];
		@(negedge clk);
		cfg_index <= REG_PT_EDGE_HIGH;
		cfg_wdata <= hi[EDGE_BITS-1:0];
		@(negedge clk);
		// unknown index must leave all edges alone
		cfg_index <= REG_UNUSED;
		cfg_wdata <= EDGE_BITS'($urandom);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		cur_edge[0] = lo;
		cur_edge[1] = mid;
		cur_edge[2] = hi;
	endtask

	task automatic send_random_particle();
		longint x, y, z, e, ed, off;
		real p;
		int k;
		case ($urandom_range(9))
			0, 1: begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
				e = $urandom;
			end
			7, 8: begin
				ed = cur_edge[$urandom_range(2)];
				if (ed > 8388600)
					ed = $urandom_range(0, 8388600);
				x = ed + $urandom_range(0, 4) - 2;
				if (x < 0)
					x = 0;
				if ($urandom_range(1))
					x = -x;
				y = $urandom_range(0, 3);
				if ($urandom_range(1))
					y = -y;
				z = $urandom_range(0, 2000000);
				e = $urandom;
			end
			9: begin
				k = $urandom_range(1, 1600000);
				x = 3 * k;
				y = 4 * k;
				if ($urandom_range(1))
					x = -x;
				if ($urandom_range(1))
					y = -y;
				z = 0;
				e = 5 * k + $urandom_range(0, 2) - 1;
			end
			default: begin
				k = $urandom_range(4, 22);
				x = $urandom_range(0, (1 << k) - 1);
				y = $urandom_range(0, (1 << k) - 1);
				z = $urandom_range(0, (1 << k) - 1);
				if ($urandom_range(1))
					x = -x;
				if ($urandom_range(1))
					y = -y;
				if ($urandom_range(1))
					z = -z;
				p = $sqrt(real'(x) * x + real'(y) * y + real'(z) * z);
				case ($urandom_range(3))
					0: off = -longint'($urandom_range(0, 3));
					1: off = $urandom_range(0, 16);
					default: off = $urandom_range(0, (1 << $urandom_range(0, 23)) - 1);
				endcase
				e = longint'(p) + off;
				if (e < 0)
					e = 0;
				if (e > EDGE_MAX)
					e = EDGE_MAX;
			end
		endcase
		send_particle(x, y, z, e);
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mom_x        = '0;
		mom_y        = '0;
		mom_z        = '0;
		energy       = '0;
		cfg_wr_en    = 1'b0;
		cfg_index    = REG_PT_EDGE_LOW;
		cfg_wdata    = '0;
		send_gap_pct = 0;
		stall_pct    = 0;
		cur_edge[0]  = EDGE_LOW_RESET;
		cur_edge[1]  = EDGE_MID_RESET;
		cur_edge[2]  = EDGE_HIGH_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				1: set_edges(0, 0, 0);
				2: set_edges(EDGE_MAX, EDGE_MAX, EDGE_MAX);
				3: set_edges(20000, 5000, 1000000);
				4: begin
					cur_edge[0] = $urandom_range(1, 3000000);
					cur_edge[1] = cur_edge[0] + $urandom_range(0, 3000000);
					cur_edge[2] = cur_edge[1] + $urandom_range(0, 3000000);
					set_edges(cur_edge[0], cur_edge[1], cur_edge[2]);
				end
				5: set_edges($urandom_range(0, 12000000), $urandom_range(0, 12000000),
					$urandom_range(0, 12000000));
				default: ;
			endcase
			case (ph % 4)
				0: begin send_gap_pct = 0;  stall_pct = 0;  end
				1: begin send_gap_pct = 53; stall_pct = 0;  end
				2: begin send_gap_pct = 0;  stall_pct = 53; end
				default: begin send_gap_pct = 13; stall_pct = 13; end
			endcase
			if (ph == 0) begin
				send_particle(0, 0, 0, 0);
				send_particle(0, 0, 0, EDGE_MAX);
				send_particle(-8388608, -8388608, -8388608, EDGE_MAX);
				send_particle(8388607, 8388607, 8388607, 0);
				send_particle(-8388608, 0, 0, 0);
				send_particle(3, 4, 0, 5);
				send_particle(3, 4, 0, 4);
				send_particle(0, 0, 0, 1);
				send_particle(9999, 0, 0, 20000);
				send_particle(10000, 0, 0, 20000);
				send_particle(0, -19999, 0, 30000);
				send_particle(0, 20000, 0, 30000);
				send_particle(29999, 0, 0, 40000);
				send_particle(30000, 0, 0, 40000);
				send_particle(-6000, -8000, 0, 10001);
				send_particle(6000, 8000, 0, 5);
				send_particle(1, 1, 1, 2);
				send_particle(0, 0, 3, 5);
				send_particle(0, 0, 0, 16777214);
				send_particle(8388607, -8388608, 1, EDGE_MAX);
			end
			repeat (ITEMS_PER_PHASE) send_random_particle();
			wait_idle();
		end

		if (err_count == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/fvm_pkg.sv
hw/rtl/fvm_sqrt.sv
hw/rtl/four_vector_mass_and_pt_bin.sv
dv/mass_pt_checker.sv
dv/tb.sv
